// File: hdl/amg_pkg.sv
// shared types and constants for the adjacency matrix graph store
// no dependencies
`timescale 1ns / 1ps

package amg_pkg;

  localparam int AMG_MAX_VERTICES = 16;
  localparam int AMG_WEIGHT_BITS  = 16;

  typedef enum logic [2:0] {
    CMD_ADD_V = 3'd0,
    CMD_DEL_V = 3'd1,
    CMD_ADD_E = 3'd2,
    CMD_DEL_E = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_FULL     = 4'd1,
    ST_RANGE    = 4'd2,
    ST_VEXISTS  = 4'd3,
    ST_NOVERTEX = 4'd4,
    ST_EMPTY    = 4'd5,
    ST_EEXISTS  = 4'd6,
    ST_BADSTART = 4'd7,
    ST_BADEND   = 4'd8,
    ST_NOEDGES  = 4'd9,
    ST_EABSENT  = 4'd10
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK_A,
    S_CHECK_B,
    S_EVAL,
    S_INIT,
    S_SET,
    S_CLR,
    S_MREAD,
    S_SCAN,
    S_SCAN_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    sel_b;
    logic    swap;
    logic    vtx_add;
    logic    vtx_del;
    logic    clr_all;
    logic    rd_target;
    logic    init_wr;
    logic    set_wr;
    logic    clr_wr;
    logic    scan_rd;
    logic    finish;
    status_t status;
  } amg_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic vtx_range;
    logic vtx_ok;
    logic full;
    logic empty;
    logic no_edges;
    logic hit;
    logic w_zero;
    logic trow_valid;
    logic k_last;
    logic scan_end;
    logic undirected;
  } amg_stat_t;

endpackage

// File: hdl/amg_ctrl.sv
// command sequencer for the graph store
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  amg_pkg::amg_stat_t  st,
  output amg_pkg::amg_cmd_t   ctl
);
  import amg_pkg::*;

  state_t  state_r, state_nxt;
  logic    mirror_r, mirror_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mirror_r <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      mirror_r <= mirror_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mirror_nxt = mirror_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_CHECK_A;
          mirror_nxt = 1'b0;
          status_nxt = ST_OK;
        end
      end
      S_CHECK_A: begin
        state_nxt = S_DONE;
        unique case (st.cmd)
          CMD_ADD_V: begin
            if (st.full) status_nxt = ST_FULL;
            else if (!st.vtx_range) status_nxt = ST_RANGE;
            else if (st.vtx_ok) status_nxt = ST_VEXISTS;
          end
          CMD_DEL_V: begin
            if (st.empty) status_nxt = ST_EMPTY;
            else if (!st.vtx_range) status_nxt = ST_RANGE;
            else if (!st.vtx_ok) status_nxt = ST_NOVERTEX;
            else state_nxt = S_SCAN;
          end
          CMD_ADD_E: begin
            if (!st.vtx_ok) status_nxt = ST_BADSTART;
            else state_nxt = S_CHECK_B;
          end
          CMD_DEL_E: begin
            if (st.no_edges) status_nxt = ST_NOEDGES;
            else if (!st.vtx_ok) status_nxt = ST_BADSTART;
            else state_nxt = S_CHECK_B;
          end
          CMD_CLEAR: begin
            status_nxt = ST_OK;
          end
          default: begin
            status_nxt = ST_RANGE;
          end
        endcase
      end
      S_CHECK_B: begin
        if (!st.vtx_ok) begin
          status_nxt = ST_BADEND;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.cmd == CMD_ADD_E) begin
          if (!mirror_r && st.hit) begin
            status_nxt = ST_EEXISTS;
            state_nxt  = S_DONE;
          end else if (!mirror_r && st.w_zero) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else if (st.trow_valid) begin
            state_nxt = S_SET;
          end else begin
            state_nxt = S_INIT;
          end
        end else begin
          if (!mirror_r && !st.hit) begin
            status_nxt = ST_EABSENT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CLR;
          end
        end
      end
      S_INIT: begin
        if (st.k_last) state_nxt = S_SET;
      end
      S_SET, S_CLR: begin
        if (!mirror_r && st.undirected) begin
          mirror_nxt = 1'b1;
          state_nxt  = S_MREAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MREAD: begin
        state_nxt = S_EVAL;
      end
      S_SCAN: begin
        if (st.scan_end) state_nxt = S_SCAN_LAST;
      end
      S_SCAN_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.swap   = mirror_r;
    ctl.status = status_r;
    busy       = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        ctl.load = start;
      end
      S_CHECK_A: begin
        ctl.vtx_add = (st.cmd == CMD_ADD_V) && !st.full && st.vtx_range && !st.vtx_ok;
        ctl.vtx_del = (st.cmd == CMD_DEL_V) && !st.empty && st.vtx_range && st.vtx_ok;
        ctl.clr_all = (st.cmd == CMD_CLEAR);
      end
      S_CHECK_B: begin
        ctl.sel_b     = 1'b1;
        ctl.rd_target = st.vtx_ok;
      end
      S_INIT: begin
        ctl.init_wr = 1'b1;
      end
      S_SET: begin
        ctl.set_wr = 1'b1;
      end
      S_CLR: begin
        ctl.clr_wr = 1'b1;
      end
      S_MREAD: begin
        ctl.rd_target = 1'b1;
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
      end
      default: begin
        ctl.finish = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/amg_dpath.sv
// datapath of the graph store: vertex bitmap, row flags, counts, weight memory
// depends on amg_pkg
`timescale 1ns / 1ps

module amg_dpath #(
  parameter int MAX_VERTICES = amg_pkg::AMG_MAX_VERTICES,
  parameter int WEIGHT_BITS  = amg_pkg::AMG_WEIGHT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_cmd,
  input  logic [7:0]         in_vertex_a,
  input  logic [7:0]         in_vertex_b,
  input  logic [15:0]        in_edge_weight_in,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  amg_pkg::amg_cmd_t  ctl,
  output amg_pkg::amg_stat_t st,
  output logic               out_valid,
  output logic [3:0]         out_status,
  output logic [4:0]         out_vertex_count_out,
  output logic [8:0]         out_edge_count_out
);
  import amg_pkg::*;

  localparam int VB        = $clog2(MAX_VERTICES);
  localparam int AW        = 2 * VB;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int VCW       = $clog2(MAX_VERTICES + 1);
  localparam int ECW       = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  cmd_t                     cmd_r;
  logic [7:0]               a_r, b_r;
  logic [WEIGHT_BITS-1:0]   w_r;
  logic                     mode_r;
  logic [MAX_VERTICES-1:0]  present_r;
  logic [MAX_VERTICES-1:0]  row_valid_r;
  logic [VCW-1:0]           vcount_r, vcount_nxt;
  logic [ECW-1:0]           ecount_r, ecount_nxt;
  logic [VB-1:0]            k_r;
  logic                     phase_r;
  logic                     pend_r;
  logic [AW-1:0]            pend_addr_r;
  logic [WEIGHT_BITS-1:0]   mem_q_r;
  logic                     rowok_r;
  logic                     out_valid_r;
  logic [3:0]               out_status_r;
  logic [4:0]               out_vcount_r;
  logic [8:0]               out_ecount_r;

  logic [WEIGHT_BITS-1:0]   mem [0:MEM_DEPTH-1];

  logic [7:0]               sel_vtx;
  logic [VB-1:0]            sel_idx, a_idx, b_idx, trow, tcol, scan_row, scan_col, rd_row;
  logic                     sel_range, hit, k_last, rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [WEIGHT_BITS-1:0]   wr_data;

  assign a_idx     = a_r[VB-1:0];
  assign b_idx     = b_r[VB-1:0];
  assign sel_vtx   = ctl.sel_b ? b_r : a_r;
  assign sel_idx   = sel_vtx[VB-1:0];
  assign sel_range = (int'(sel_vtx) < MAX_VERTICES);
  assign trow      = ctl.swap ? b_idx : a_idx;
  assign tcol      = ctl.swap ? a_idx : b_idx;
  assign scan_row  = phase_r ? k_r : a_idx;
  assign scan_col  = phase_r ? a_idx : k_r;
  assign rd_en     = ctl.rd_target | ctl.scan_rd;
  assign rd_addr   = ctl.scan_rd ? {scan_row, scan_col} : {trow, tcol};
  assign rd_row    = ctl.scan_rd ? scan_row : trow;
  assign hit       = rowok_r && (mem_q_r != '0);
  assign k_last    = (k_r == VB'(MAX_VERTICES - 1));

  // pending scan clear wins the write port; the sequencer never overlaps them
  assign wr_en   = ctl.init_wr | ctl.set_wr | ((ctl.clr_wr | pend_r) & hit);
  assign wr_addr = pend_r ? pend_addr_r : (ctl.init_wr ? {trow, k_r} : {trow, tcol});
  assign wr_data = ctl.set_wr ? w_r : '0;

  always_comb begin
    st            = '0;
    st.cmd        = cmd_r;
    st.vtx_range  = sel_range;
    st.vtx_ok     = sel_range && present_r[sel_idx];
    st.full       = (vcount_r == VCW'(MAX_VERTICES));
    st.empty      = (vcount_r == '0);
    st.no_edges   = (ecount_r == '0);
    st.hit        = hit;
    st.w_zero     = (w_r == '0);
    st.trow_valid = row_valid_r[trow];
    st.k_last     = k_last;
    st.scan_end   = phase_r & k_last;
    st.undirected = mode_r;
  end

  always_comb begin
    vcount_nxt = vcount_r;
    if (ctl.clr_all) vcount_nxt = '0;
    else if (ctl.vtx_add) vcount_nxt = vcount_r + VCW'(1);
    else if (ctl.vtx_del) vcount_nxt = vcount_r - VCW'(1);
  end

  always_comb begin
    ecount_nxt = ecount_r;
    if (ctl.clr_all) ecount_nxt = '0;
    else if (ctl.set_wr && !hit) ecount_nxt = ecount_r + ECW'(1);
    else if ((ctl.clr_wr || pend_r) && hit) ecount_nxt = ecount_r - ECW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      present_r   <= '0;
      row_valid_r <= '0;
      vcount_r    <= '0;
      ecount_r    <= '0;
      k_r         <= '0;
      phase_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      vcount_r    <= vcount_nxt;
      ecount_r    <= ecount_nxt;
      pend_r      <= ctl.scan_rd;
      out_valid_r <= ctl.finish;
      if (ctl.clr_all) begin
        present_r   <= '0;
        row_valid_r <= '0;
      end else begin
        if (ctl.vtx_add) present_r[a_idx] <= 1'b1;
        if (ctl.vtx_del) present_r[a_idx] <= 1'b0;
        if (ctl.init_wr && k_last) row_valid_r[trow] <= 1'b1;
      end
      if (ctl.init_wr || ctl.scan_rd) begin
        if (k_last) begin
          k_r <= '0;
          if (ctl.scan_rd) phase_r <= ~phase_r;
        end else begin
          k_r <= k_r + VB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_t'(in_cmd);
      a_r   <= in_vertex_a;
      b_r   <= in_vertex_b;
      w_r   <= WEIGHT_BITS'(in_edge_weight_in);
    end
    if (ctl.scan_rd) pend_addr_r <= {scan_row, scan_col};
    if (ctl.finish) begin
      out_status_r <= ctl.status;
      out_vcount_r <= 5'(vcount_r);
      out_ecount_r <= 9'(ecount_r);
    end
  end

  // weight memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      rowok_r <= row_valid_r[rd_row];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_vertex_count_out = out_vcount_r;
  assign out_edge_count_out   = out_ecount_r;

endmodule

// File: hdl/adjacency_matrix_graph_store.sv
// an accepted command runs through the check states, then any row init, write, mirror or scan
// states, then S_DONE; out_valid is registered from the finish strobe of S_DONE
// busy drops in the out_valid cycle; a new command is taken only after the last is done; no stall
// synchronous active-low reset clears bitmap, counts, mode and per-row valid flags at once
// top level: instantiates amg_ctrl and amg_dpath, uses amg_pkg
`timescale 1ns / 1ps

module adjacency_matrix_graph_store #(
  parameter int MAX_VERTICES = amg_pkg::AMG_MAX_VERTICES,
  parameter int WEIGHT_BITS  = amg_pkg::AMG_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_vertex_a,
  input  logic [7:0]  in_vertex_b,
  input  logic [15:0] in_edge_weight_in,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  output logic [3:0]  out_status,
  output logic [4:0]  out_vertex_count_out,
  output logic [8:0]  out_edge_count_out
);
  import amg_pkg::*;

  amg_cmd_t  ctl;
  amg_stat_t st;

  amg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  amg_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_cmd               (in_cmd),
    .in_vertex_a          (in_vertex_a),
    .in_vertex_b          (in_vertex_b),
    .in_edge_weight_in    (in_edge_weight_in),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .ctl                  (ctl),
    .st                   (st),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_vertex_count_out (out_vertex_count_out),
    .out_edge_count_out   (out_edge_count_out)
  );

endmodule

// File: dv/adjacency_matrix_graph_store_test.sv
// testbench for adjacency_matrix_graph_store: directed command table, then random command phases
// that switch undirected mode; results are checked against typed rows or an in-bench graph predictor
// depends on amg_pkg and the adjacency_matrix_graph_store rtl
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_test;
  import amg_pkg::*;

  localparam int MAXV = AMG_MAX_VERTICES;
  localparam int CELLS = MAXV * MAXV;
  localparam int NUM_DIR = 25;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int SETTLE_CYCLES = 3 * MAXV + 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  typedef struct packed {
    status_t    status;
    logic [4:0] vertices;
    logic [8:0] edges;
  } graph_result_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [7:0]    va;
    logic [7:0]    vb;
    logic [15:0]   weight;
    logic          typed;
    graph_result_t res;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [7:0]  in_vertex_a;
  logic [7:0]  in_vertex_b;
  logic [15:0] in_edge_weight_in;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        out_valid;
  logic [3:0]  out_status;
  logic [4:0]  out_vertex_count_out;
  logic [8:0]  out_edge_count_out;

  // predictor state
  bit          vtx_on [MAXV];
  logic [15:0] wt_mem [CELLS];
  int          vtx_total;
  int          edge_total;
  bit          mirror_mode;

  graph_result_t result_fifo [$];
  cmd_row_t      dir_rows [NUM_DIR];
  int            errors;
  int            cycles;

  adjacency_matrix_graph_store dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_vertex_a          (in_vertex_a),
    .in_vertex_b          (in_vertex_b),
    .in_edge_weight_in    (in_edge_weight_in),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_vertex_count_out (out_vertex_count_out),
    .out_edge_count_out   (out_edge_count_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit vtx_valid(input logic [7:0] v);
    return (int'(v) < MAXV) && vtx_on[int'(v)];
  endfunction

  function automatic void set_weight(input int idx, input logic [15:0] w);
    if (wt_mem[idx] == 16'd0) edge_total++;
    wt_mem[idx] = w;
  endfunction

  function automatic void clear_weight(input int idx);
    if (wt_mem[idx] != 16'd0) begin
      wt_mem[idx] = 16'd0;
      edge_total--;
    end
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < MAXV; i++) vtx_on[i] = 1'b0;
    for (int i = 0; i < CELLS; i++) wt_mem[i] = 16'd0;
    vtx_total = 0;
    edge_total = 0;
  endfunction

  function automatic graph_result_t apply_graph_cmd(input logic [2:0] c, input logic [7:0] a,
                                                    input logic [7:0] b, input logic [15:0] w);
    graph_result_t r;
    status_t st;
    int ia;
    int ib;
    ia = int'(a);
    ib = int'(b);
    case (c)
      CMD_ADD_V: begin
        if (vtx_total == MAXV) st = ST_FULL;
        else if (ia >= MAXV) st = ST_RANGE;
        else if (vtx_on[ia]) st = ST_VEXISTS;
        else begin
          vtx_on[ia] = 1'b1;
          vtx_total++;
          st = ST_OK;
        end
      end
      CMD_DEL_V: begin
        if (vtx_total == 0) st = ST_EMPTY;
        else if (ia >= MAXV) st = ST_RANGE;
        else if (!vtx_on[ia]) st = ST_NOVERTEX;
        else begin
          vtx_on[ia] = 1'b0;
          vtx_total--;
          for (int i = 0; i < MAXV; i++) begin
            clear_weight(ia * MAXV + i);
            clear_weight(i * MAXV + ia);
          end
          st = ST_OK;
        end
      end
      CMD_ADD_E: begin
        if (!vtx_valid(a)) st = ST_BADSTART;
        else if (!vtx_valid(b)) st = ST_BADEND;
        else if (wt_mem[ia * MAXV + ib] != 16'd0) st = ST_EEXISTS;
        else if (w == 16'd0) st = ST_RANGE;
        else begin
          set_weight(ia * MAXV + ib, w);
          if (mirror_mode) set_weight(ib * MAXV + ia, w);
          st = ST_OK;
        end
      end
      CMD_DEL_E: begin
        if (edge_total == 0) st = ST_NOEDGES;
        else if (!vtx_valid(a)) st = ST_BADSTART;
        else if (!vtx_valid(b)) st = ST_BADEND;
        else if (wt_mem[ia * MAXV + ib] == 16'd0) st = ST_EABSENT;
        else begin
          clear_weight(ia * MAXV + ib);
          if (mirror_mode) clear_weight(ib * MAXV + ia);
          st = ST_OK;
        end
      end
      CMD_CLEAR: begin
        wipe_graph();
        st = ST_OK;
      end
      default: st = ST_RANGE;
    endcase
    r.status = st;
    r.vertices = vtx_total[4:0];
    r.edges = edge_total[8:0];
    return r;
  endfunction

  // returns -1 when no vertex is in the wanted state
  function automatic int find_vertex(input bit want_on);
    int base;
    base = $urandom_range(0, MAXV - 1);
    for (int i = 0; i < MAXV; i++)
      if (vtx_on[(base + i) % MAXV] == want_on) return (base + i) % MAXV;
    return -1;
  endfunction

  function automatic int find_edge();
    int base;
    base = $urandom_range(0, CELLS - 1);
    for (int i = 0; i < CELLS; i++)
      if (wt_mem[(base + i) % CELLS] != 16'd0) return (base + i) % CELLS;
    return -1;
  endfunction

  function automatic logic [7:0] pick_vertex(input bit want_on, input int bias);
    int v;
    if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < bias) begin
      v = find_vertex(want_on);
      if (v >= 0) return 8'(v);
    end
    return 8'($urandom_range(0, MAXV - 1));
  endfunction

  task automatic issue_cmd(input logic [2:0] c, input logic [7:0] a, input logic [7:0] b,
                           input logic [15:0] w, input bit typed, input graph_result_t typed_res);
    graph_result_t r;
    start <= 1'b1;
    in_cmd <= c;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_edge_weight_in <= w;
    do @(posedge clk); while (busy !== 1'b0);
    r = apply_graph_cmd(c, a, b, w);
    result_fifo.push_back(typed ? typed_res : r);
  endtask

  task automatic issue_random();
    logic [2:0] c;
    logic [7:0] a;
    logic [7:0] b;
    logic [15:0] w;
    int sel;
    int e;
    sel = $urandom_range(0, 99);
    a = pick_vertex(1'b1, 75);
    b = pick_vertex(1'b1, 75);
    if ($urandom_range(0, 9) == 0) b = a;
    sel = $urandom_range(0, 99);
    if (sel < 4) w = 16'd0;
    else if (sel < 10) w = 16'hffff;
    else if (sel < 14) w = 16'd1;
    else w = 16'($urandom_range(1, 65535));
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      c = CMD_ADD_V;
      a = pick_vertex(1'b0, 45);
    end else if (sel < 30) begin
      c = CMD_DEL_V;
      a = pick_vertex(1'b1, 65);
    end else if (sel < 62) begin
      c = CMD_ADD_E;
    end else if (sel < 95) begin
      c = CMD_DEL_E;
      e = find_edge();
      if (e >= 0 && $urandom_range(0, 99) < 60) begin
        a = 8'(e / MAXV);
        b = 8'(e % MAXV);
      end
    end else if (sel < 96) begin
      c = CMD_CLEAR;
    end else begin
      c = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    end
    issue_cmd(c, a, b, w, 1'b0, '0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_mode = m;
  endtask

  always @(posedge clk) begin
    graph_result_t exp_res;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (result_fifo.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_res = result_fifo.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          errors++;
        end
        if (out_vertex_count_out !== exp_res.vertices) begin
          $error("vertex_count_out: expected %0d, got %0d", exp_res.vertices,
                 out_vertex_count_out);
          errors++;
        end
        if (out_edge_count_out !== exp_res.edges) begin
          $error("edge_count_out: expected %0d, got %0d", exp_res.edges, out_edge_count_out);
          errors++;
        end
      end
    end
  end

  initial begin
    bit idle_on;
    int phase_mode [NUM_PHASES];
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_vertex_a = '0;
    in_vertex_b = '0;
    in_edge_weight_in = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    mirror_mode = 1'b0;
    wipe_graph();
    phase_mode = '{0, 1, 0, 1, 1, 0};
    dir_rows = '{
      '{CMD_DEL_V, 8'd0,   8'd0,   16'd0,      1'b1, '{ST_EMPTY,    5'd0, 9'd0}},
      '{CMD_DEL_E, 8'd0,   8'd0,   16'd0,      1'b1, '{ST_NOEDGES,  5'd0, 9'd0}},
      '{CMD_ADD_E, 8'd0,   8'd1,   16'd5,      1'b1, '{ST_BADSTART, 5'd0, 9'd0}},
      '{CMD_ADD_V, 8'd255, 8'd0,   16'd0,      1'b1, '{ST_RANGE,    5'd0, 9'd0}},
      '{CMD_ADD_V, 8'd16,  8'd0,   16'd0,      1'b1, '{ST_RANGE,    5'd0, 9'd0}},
      '{CMD_ADD_V, 8'd0,   8'd0,   16'd0,      1'b1, '{ST_OK,       5'd1, 9'd0}},
      '{CMD_ADD_V, 8'd0,   8'd0,   16'd0,      1'b1, '{ST_VEXISTS,  5'd1, 9'd0}},
      '{CMD_ADD_V, 8'd15,  8'd0,   16'd0,      1'b1, '{ST_OK,       5'd2, 9'd0}},
      '{CMD_DEL_V, 8'd16,  8'd0,   16'd0,      1'b1, '{ST_RANGE,    5'd2, 9'd0}},
      '{CMD_DEL_V, 8'd3,   8'd0,   16'd0,      1'b1, '{ST_NOVERTEX, 5'd2, 9'd0}},
      '{CMD_ADD_E, 8'd0,   8'd15,  16'd0,      1'b1, '{ST_RANGE,    5'd2, 9'd0}},
      '{CMD_ADD_E, 8'd0,   8'd15,  16'hffff,   1'b1, '{ST_OK,       5'd2, 9'd1}},
      '{CMD_ADD_E, 8'd0,   8'd15,  16'd1,      1'b1, '{ST_EEXISTS,  5'd2, 9'd1}},
      '{CMD_ADD_E, 8'd0,   8'd0,   16'h8000,   1'b1, '{ST_OK,       5'd2, 9'd2}},
      '{CMD_ADD_E, 8'd0,   8'd255, 16'd9,      1'b1, '{ST_BADEND,   5'd2, 9'd2}},
      '{CMD_ADD_E, 8'd7,   8'd0,   16'd9,      1'b1, '{ST_BADSTART, 5'd2, 9'd2}},
      '{CMD_DEL_E, 8'd15,  8'd0,   16'd0,      1'b1, '{ST_EABSENT,  5'd2, 9'd2}},
      '{CMD_DEL_E, 8'd255, 8'd0,   16'd0,      1'b1, '{ST_BADSTART, 5'd2, 9'd2}},
      '{CMD_DEL_E, 8'd0,   8'd128, 16'd0,      1'b1, '{ST_BADEND,   5'd2, 9'd2}},
      '{CMD_BAD_LO, 8'hff, 8'hff,  16'hffff,   1'b1, '{ST_RANGE,    5'd2, 9'd2}},
      '{CMD_BAD_HI, 8'd0,  8'd0,   16'd0,      1'b1, '{ST_RANGE,    5'd2, 9'd2}},
      '{CMD_ADD_E, 8'd15,  8'd15,  16'h7fff,   1'b0, '{ST_OK,       5'd0, 9'd0}},
      '{CMD_DEL_E, 8'd0,   8'd15,  16'd0,      1'b0, '{ST_OK,       5'd0, 9'd0}},
      '{CMD_DEL_V, 8'd0,   8'd0,   16'd0,      1'b0, '{ST_OK,       5'd0, 9'd0}},
      '{CMD_CLEAR, 8'd0,   8'd0,   16'd0,      1'b1, '{ST_OK,       5'd0, 9'd0}}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      issue_cmd(dir_rows[i].cmd, dir_rows[i].va, dir_rows[i].vb, dir_rows[i].weight,
                dir_rows[i].typed, dir_rows[i].res);

    idle_on = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_mode[p][0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(0, 39) == 0) idle_on = ~idle_on;
        // sender gaps, none in the last phase
        if (p < NUM_PHASES - 1 && idle_on && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        issue_random();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
